// ----- sv/sfb_pkg.sv -----
// sfb_pkg: shared types and codes for the sweep frame builder
// request/result structs for both channels and the two arithmetic units
// no dependencies
package sfb_pkg;

  // input request: tangent and second derivative, signed Q16.16
  typedef struct packed {
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic signed [31:0] tangent_z;
    logic signed [31:0] curvature_x;
    logic signed [31:0] curvature_y;
    logic signed [31:0] curvature_z;
    logic               sweep_start;
  } sfb_in_t;

  // result request: frame axes in signed Q2.30 plus status
  typedef struct packed {
    logic signed [31:0] axis_x_x;
    logic signed [31:0] axis_x_y;
    logic signed [31:0] axis_x_z;
    logic signed [31:0] axis_y_x;
    logic signed [31:0] axis_y_y;
    logic signed [31:0] axis_y_z;
    logic signed [31:0] axis_z_x;
    logic signed [31:0] axis_z_y;
    logic signed [31:0] axis_z_z;
    logic [1:0]         status;
  } sfb_out_t;

  // status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_DISC  = 2'd1;
  localparam logic [1:0] STAT_ZTAN  = 2'd2;
  localparam logic [1:0] STAT_DEGEN = 2'd3;

  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

  // digit-serial multiplier interface
  typedef struct packed {
    logic               go;
    logic signed [33:0] a;
    logic signed [31:0] b;
  } sfb_mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [65:0] prod;
  } sfb_mul_rsp_t;

  // bit-serial root / divide interface
  typedef struct packed {
    logic        go;
    logic        op_sqrt;
    logic [63:0] num;
    logic [31:0] den;
  } sfb_ds_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } sfb_ds_rsp_t;

endpackage

// ----- sv/sfb_mul.sv -----
// sfb_mul: signed 34x32 multiplier, one 4-bit digit of b per cycle
// uses sfb_pkg for the request/result structs
module sfb_mul import sfb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  sfb_mul_req_t req,
  output sfb_mul_rsp_t rsp
);

  logic               busy_r;
  logic               fin_r;
  logic               done_r;
  logic [2:0]         cnt_r;
  logic [33:0]        amag_r;
  logic [31:0]        bsh_r;
  logic [65:0]        acc_r;
  logic               neg_r;
  logic signed [65:0] prod_r;
  logic [37:0]        part;

  // partial product of |a| and the top digit of |b|
  assign part = amag_r * bsh_r[31:28];

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= fin_r;
      fin_r  <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= 3'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  // magnitude accumulation, msb digit first
  always_ff @(posedge clk) begin
    if (req.go) begin
      amag_r <= req.a[33] ? (~req.a + 34'd1) : req.a;
      bsh_r  <= req.b[31] ? (~req.b + 32'd1) : req.b;
      acc_r  <= 66'd0;
      neg_r  <= req.a[33] ^ req.b[31];
    end else if (busy_r) begin
      acc_r <= {acc_r[61:0], 4'b0} + {28'b0, part};
      bsh_r <= {bsh_r[27:0], 4'b0};
    end
    if (fin_r) begin
      prod_r <= neg_r ? (~acc_r + 66'd1) : acc_r;
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = prod_r;

endmodule

// ----- sv/sfb_divsqrt.sv -----
// sfb_divsqrt: shared bit-serial unit, 32 result bits one per cycle
// floor square root of a 64-bit value or 32-bit quotient num / den
// uses sfb_pkg for the request/result structs
module sfb_divsqrt import sfb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  sfb_ds_req_t req,
  output sfb_ds_rsp_t rsp
);

  logic        busy_r;
  logic        done_r;
  logic        op_r;
  logic [4:0]  cnt_r;
  logic [35:0] rem_r;
  logic [63:0] sh_r;
  logic [31:0] res_r;
  logic [31:0] den_r;
  logic [35:0] remx;
  logic [35:0] trial;
  logic [35:0] diff;
  logic        ge;

  // one restoring step
  always_comb begin
    if (op_r) begin
      remx  = {rem_r[33:0], sh_r[63:62]};
      trial = {2'b0, res_r, 2'b01};
    end else begin
      remx  = {rem_r[34:0], sh_r[63]};
      trial = {4'b0, den_r};
    end
    ge   = (remx >= trial);
    diff = remx - trial;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.go) begin
      op_r  <= req.op_sqrt;
      rem_r <= req.op_sqrt ? 36'd0 : {4'b0, req.num[63:32]};
      sh_r  <= req.op_sqrt ? req.num : {req.num[31:0], 32'b0};
      res_r <= 32'd0;
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= ge ? diff : remx;
      res_r <= {res_r[30:0], ge};
      sh_r  <= op_r ? {sh_r[61:0], 2'b0} : {sh_r[62:0], 1'b0};
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule

// ----- sv/sweep_frame_builder.sv -----
// Sweep frame builder: takes one request at a time and returns one orthonormal frame
// (unit tangent x, unit normal z, y = z cross x, all signed Q2.30) with a status code.
// Each of the up to 27 products goes through a 4-bit digit-serial multiplier, and each
// normalization runs a shift search, one square root and three divisions on a shared
// bit-serial unit. The unit tangent, the cross-product normal and, when that is zero, the
// projected previous normal are normalized one after another, and the stored normal is
// updated when the frame is handed to the result register. in_stall is low only while
// the block is idle; a finished frame waits in the result register without holding off
// the next request.
// depends on sfb_pkg, sfb_mul, sfb_divsqrt
module sweep_frame_builder import sfb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sfb_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output sfb_out_t out_data
);

  // sequencer codes
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_NLOAD  = 4'd1;
  localparam logic [3:0] ST_NSCALE = 4'd2;
  localparam logic [3:0] ST_NSQ    = 4'd3;
  localparam logic [3:0] ST_NSQRT  = 4'd4;
  localparam logic [3:0] ST_NDIV   = 4'd5;
  localparam logic [3:0] ST_NRET   = 4'd6;
  localparam logic [3:0] ST_CROSS  = 4'd7;
  localparam logic [3:0] ST_DISC   = 4'd8;
  localparam logic [3:0] ST_DOTD   = 4'd9;
  localparam logic [3:0] ST_DRND   = 4'd10;
  localparam logic [3:0] ST_PROJ   = 4'd11;
  localparam logic [3:0] ST_YAX    = 4'd12;
  localparam logic [3:0] ST_YRND   = 4'd13;
  localparam logic [3:0] ST_EMIT   = 4'd14;

  // which vector the normalizer is working on
  localparam logic [1:0] NS_TAN = 2'd0;
  localparam logic [1:0] NS_CRS = 2'd1;
  localparam logic [1:0] NS_PRJ = 2'd2;

  logic [3:0] state_r, state_nxt;
  logic [2:0] k_r, k_nxt;
  logic       wait_r, wait_nxt;
  logic       out_valid_r;
  sfb_out_t   out_r;

  logic signed [31:0] t_r [3];
  logic signed [31:0] c_r [3];
  logic signed [31:0] prev_r [3];
  logic signed [31:0] pn_r [3];
  logic signed [31:0] x_r [3];
  logic signed [31:0] z_r [3];
  logic signed [31:0] y_r [3];
  logic signed [31:0] nu_r [3];
  logic signed [63:0] w_r [3];
  logic [63:0]        nm_r [3];
  logic [2:0]         nneg_r;
  logic               start_r;
  logic [1:0]         status_r;
  logic [1:0]         nsel_r;
  logic               nok_r;
  logic signed [63:0] acc_r;
  logic signed [33:0] d_r;
  logic [63:0]        nsum_r;
  logic [31:0]        nn_r;

  sfb_mul_req_t mul_req;
  sfb_mul_rsp_t mul_rsp;
  sfb_ds_req_t  ds_req;
  sfb_ds_rsp_t  ds_rsp;

  logic        accept;
  logic        out_free;
  logic        mul_state;
  logic        mul_take;
  logic        ds_take;
  logic        mul_last;
  logic [1:0]  ia;
  logic [1:0]  ib;
  logic [63:0] nmk;
  logic [63:0] div_num;
  logic        w_zero;
  logic        any_hi;
  logic        all_lo;

  function automatic logic [31:0] sel3_32(input logic [1:0] i, input logic [31:0] a0,
                                          input logic [31:0] a1, input logic [31:0] a2);
    case (i)
      2'd0:    return a0;
      2'd1:    return a1;
      default: return a2;
    endcase
  endfunction

  function automatic logic [63:0] sel3_64(input logic [1:0] i, input logic [63:0] a0,
                                          input logic [63:0] a1, input logic [63:0] a2);
    case (i)
      2'd0:    return a0;
      2'd1:    return a1;
      default: return a2;
    endcase
  endfunction

  // Q4.60 to Q2.30, half away from zero, wide result for the projection dot
  function automatic logic [33:0] rnd_d(input logic [63:0] v);
    logic [63:0] m;
    logic [63:0] r;
    m = v[63] ? (~v + 64'd1) : v;
    r = (m + (64'd1 << 29)) >> 30;
    return v[63] ? (~r[33:0] + 34'd1) : r[33:0];
  endfunction

  // Q4.60 to Q2.30, half away from zero, clamped to +-1.0
  function automatic logic [31:0] rnd_sat(input logic [63:0] v);
    logic [63:0] m;
    logic [63:0] r;
    logic [31:0] q;
    m = v[63] ? (~v + 64'd1) : v;
    r = (m + (64'd1 << 29)) >> 30;
    q = (r > 64'h4000_0000) ? 32'h4000_0000 : r[31:0];
    return v[63] ? (~q + 32'd1) : q;
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign mul_state = (state_r == ST_NSQ) || (state_r == ST_CROSS) || (state_r == ST_DISC) ||
                     (state_r == ST_DOTD) || (state_r == ST_PROJ) || (state_r == ST_YAX);
  assign mul_take  = wait_r && mul_rsp.done;
  assign ds_take   = wait_r && ds_rsp.done;
  assign mul_last  = ((state_r == ST_CROSS) || (state_r == ST_YAX)) ? (k_r == 3'd5)
                                                                     : (k_r == 3'd2);

  // normalizer tests
  assign w_zero = (w_r[0] == 64'd0) && (w_r[1] == 64'd0) && (w_r[2] == 64'd0);
  assign any_hi = (|nm_r[0][63:31]) || (|nm_r[1][63:31]) || (|nm_r[2][63:31]);
  assign all_lo = !((|nm_r[0][63:30]) || (|nm_r[1][63:30]) || (|nm_r[2][63:30]));
  assign nmk    = sel3_64(k_r[1:0], nm_r[0], nm_r[1], nm_r[2]);
  assign div_num = ({33'b0, nmk[30:0]} << 30) + {33'b0, nn_r[31:1]};

  // component order of the two cross products
  always_comb begin
    case (k_r)
      3'd0:    begin ia = 2'd1; ib = 2'd2; end
      3'd1:    begin ia = 2'd2; ib = 2'd1; end
      3'd2:    begin ia = 2'd2; ib = 2'd0; end
      3'd3:    begin ia = 2'd0; ib = 2'd2; end
      3'd4:    begin ia = 2'd0; ib = 2'd1; end
      default: begin ia = 2'd1; ib = 2'd0; end
    endcase
  end

  // multiplier operands
  always_comb begin
    logic [31:0] sa;
    logic [31:0] sb;
    sa = 32'd0;
    sb = 32'd0;
    mul_req.go = mul_state && !wait_r;
    mul_req.a  = 34'sd0;
    mul_req.b  = 32'sd0;
    case (state_r)
      ST_NSQ: begin
        mul_req.a = {3'b0, nmk[30:0]};
        mul_req.b = {1'b0, nmk[30:0]};
      end
      ST_CROSS: begin
        sa = sel3_32(ia, t_r[0], t_r[1], t_r[2]);
        sb = sel3_32(ib, c_r[0], c_r[1], c_r[2]);
        mul_req.a = {{2{sa[31]}}, sa};
        mul_req.b = sb;
      end
      ST_YAX: begin
        sa = sel3_32(ia, z_r[0], z_r[1], z_r[2]);
        sb = sel3_32(ib, x_r[0], x_r[1], x_r[2]);
        mul_req.a = {{2{sa[31]}}, sa};
        mul_req.b = sb;
      end
      ST_DISC: begin
        sa = sel3_32(k_r[1:0], z_r[0], z_r[1], z_r[2]);
        sb = sel3_32(k_r[1:0], prev_r[0], prev_r[1], prev_r[2]);
        mul_req.a = {{2{sa[31]}}, sa};
        mul_req.b = sb;
      end
      ST_DOTD: begin
        sa = sel3_32(k_r[1:0], prev_r[0], prev_r[1], prev_r[2]);
        sb = sel3_32(k_r[1:0], x_r[0], x_r[1], x_r[2]);
        mul_req.a = {{2{sa[31]}}, sa};
        mul_req.b = sb;
      end
      ST_PROJ: begin
        mul_req.a = d_r;
        mul_req.b = sel3_32(k_r[1:0], x_r[0], x_r[1], x_r[2]);
      end
      default: begin
        mul_req.a = 34'sd0;
        mul_req.b = 32'sd0;
      end
    endcase
  end

  // root / divide requests
  assign ds_req.go      = ((state_r == ST_NSQRT) || (state_r == ST_NDIV)) && !wait_r;
  assign ds_req.op_sqrt = (state_r == ST_NSQRT);
  assign ds_req.num     = (state_r == ST_NSQRT) ? nsum_r : div_num;
  assign ds_req.den     = nn_r;

  sfb_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  sfb_divsqrt u_ds (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ds_req),
    .rsp   (ds_rsp)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    wait_nxt  = wait_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_NLOAD;
      end
      ST_NLOAD: begin
        state_nxt = w_zero ? ST_NRET : ST_NSCALE;
      end
      ST_NSCALE: begin
        if (!any_hi && !all_lo) begin
          state_nxt = ST_NSQ;
          k_nxt     = 3'd0;
        end
      end
      ST_NSQ, ST_CROSS, ST_DISC, ST_DOTD, ST_PROJ, ST_YAX: begin
        if (!wait_r) begin
          wait_nxt = 1'b1;
        end else if (mul_take) begin
          wait_nxt = 1'b0;
          if (mul_last) begin
            k_nxt = 3'd0;
            case (state_r)
              ST_NSQ:   state_nxt = ST_NSQRT;
              ST_CROSS: state_nxt = ST_NLOAD;
              ST_DISC:  state_nxt = ST_YAX;
              ST_DOTD:  state_nxt = ST_DRND;
              ST_PROJ:  state_nxt = ST_NLOAD;
              default:  state_nxt = ST_YRND;
            endcase
          end else begin
            k_nxt = k_r + 3'd1;
          end
        end
      end
      ST_NSQRT: begin
        if (!wait_r) begin
          wait_nxt = 1'b1;
        end else if (ds_take) begin
          wait_nxt  = 1'b0;
          state_nxt = ST_NDIV;
          k_nxt     = 3'd0;
        end
      end
      ST_NDIV: begin
        if (!wait_r) begin
          wait_nxt = 1'b1;
        end else if (ds_take) begin
          wait_nxt = 1'b0;
          if (k_r == 3'd2) begin
            state_nxt = ST_NRET;
            k_nxt     = 3'd0;
          end else begin
            k_nxt = k_r + 3'd1;
          end
        end
      end
      ST_NRET: begin
        k_nxt = 3'd0;
        case (nsel_r)
          NS_TAN:  state_nxt = nok_r ? ST_CROSS : ST_YAX;
          NS_CRS:  state_nxt = nok_r ? (start_r ? ST_YAX : ST_DISC) : ST_DOTD;
          default: state_nxt = ST_YAX;
        endcase
      end
      ST_DRND: begin
        state_nxt = ST_PROJ;
        k_nxt     = 3'd0;
      end
      ST_YRND: begin
        if (k_r == 3'd2) begin
          state_nxt = ST_EMIT;
          k_nxt     = 3'd0;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      ST_EMIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
        k_nxt     = 3'd0;
        wait_nxt  = 1'b0;
      end
    endcase
  end

  // control registers and stored normal
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= 3'd0;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pn_r[0]     <= 32'sd0;
      pn_r[1]     <= 32'sd0;
      pn_r[2]     <= ONE_Q30;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      wait_r  <= wait_nxt;
      if (state_r == ST_EMIT && out_free) begin
        out_valid_r <= 1'b1;
        pn_r[0]     <= z_r[0];
        pn_r[1]     <= z_r[1];
        pn_r[2]     <= z_r[2];
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          t_r[0]   <= in_data.tangent_x;
          t_r[1]   <= in_data.tangent_y;
          t_r[2]   <= in_data.tangent_z;
          c_r[0]   <= in_data.curvature_x;
          c_r[1]   <= in_data.curvature_y;
          c_r[2]   <= in_data.curvature_z;
          start_r  <= in_data.sweep_start;
          prev_r[0] <= in_data.sweep_start ? 32'sd0 : pn_r[0];
          prev_r[1] <= in_data.sweep_start ? 32'sd0 : pn_r[1];
          prev_r[2] <= in_data.sweep_start ? ONE_Q30 : pn_r[2];
          w_r[0]   <= {{32{in_data.tangent_x[31]}}, in_data.tangent_x};
          w_r[1]   <= {{32{in_data.tangent_y[31]}}, in_data.tangent_y};
          w_r[2]   <= {{32{in_data.tangent_z[31]}}, in_data.tangent_z};
          status_r <= STAT_OK;
          nsel_r   <= NS_TAN;
        end
      end
      ST_NLOAD: begin
        nm_r[0] <= mag64(w_r[0]);
        nm_r[1] <= mag64(w_r[1]);
        nm_r[2] <= mag64(w_r[2]);
        nneg_r  <= {w_r[2][63], w_r[1][63], w_r[0][63]};
        nsum_r  <= 64'd0;
        nok_r   <= 1'b0;
      end
      ST_NSCALE: begin
        // bring the largest magnitude into [2^30, 2^31)
        if (any_hi) begin
          nm_r[0] <= nm_r[0] >> 1;
          nm_r[1] <= nm_r[1] >> 1;
          nm_r[2] <= nm_r[2] >> 1;
        end else if (all_lo) begin
          nm_r[0] <= nm_r[0] << 1;
          nm_r[1] <= nm_r[1] << 1;
          nm_r[2] <= nm_r[2] << 1;
        end
      end
      ST_NSQ: begin
        if (mul_take) nsum_r <= nsum_r + mul_rsp.prod[63:0];
      end
      ST_NSQRT: begin
        if (ds_take) nn_r <= ds_rsp.res;
      end
      ST_NDIV: begin
        if (ds_take) begin
          nu_r[k_r[1:0]] <= nneg_r[k_r[1:0]] ? (~ds_rsp.res + 32'd1) : ds_rsp.res;
          if (k_r == 3'd2) nok_r <= 1'b1;
        end
      end
      ST_NRET: begin
        acc_r <= 64'sd0;
        case (nsel_r)
          NS_TAN: begin
            if (nok_r) begin
              x_r[0] <= nu_r[0];
              x_r[1] <= nu_r[1];
              x_r[2] <= nu_r[2];
            end else begin
              status_r <= STAT_ZTAN;
              x_r[0]   <= 32'sd0;
              x_r[1]   <= 32'sd0;
              x_r[2]   <= 32'sd0;
              z_r[0]   <= prev_r[0];
              z_r[1]   <= prev_r[1];
              z_r[2]   <= prev_r[2];
            end
          end
          NS_CRS: begin
            if (nok_r) begin
              z_r[0] <= nu_r[0];
              z_r[1] <= nu_r[1];
              z_r[2] <= nu_r[2];
            end
          end
          default: begin
            if (nok_r) begin
              z_r[0] <= nu_r[0];
              z_r[1] <= nu_r[1];
              z_r[2] <= nu_r[2];
            end else begin
              status_r <= STAT_DEGEN;
              z_r[0]   <= prev_r[0];
              z_r[1]   <= prev_r[1];
              z_r[2]   <= prev_r[2];
            end
          end
        endcase
      end
      ST_CROSS, ST_YAX: begin
        // even step keeps the first term, odd step subtracts the second
        if (mul_take) begin
          if (!k_r[0]) acc_r <= mul_rsp.prod[63:0];
          else         w_r[k_r[2:1]] <= acc_r - mul_rsp.prod[63:0];
          if (mul_last && state_r == ST_CROSS) nsel_r <= NS_CRS;
        end
      end
      ST_DISC: begin
        if (mul_take) begin
          acc_r <= acc_r + mul_rsp.prod[63:0];
          if (mul_last && (acc_r + mul_rsp.prod[63:0]) == 64'sd0) status_r <= STAT_DISC;
        end
      end
      ST_DOTD: begin
        if (mul_take) acc_r <= acc_r + mul_rsp.prod[63:0];
      end
      ST_DRND: begin
        d_r    <= rnd_d(acc_r);
        nsel_r <= NS_PRJ;
      end
      ST_PROJ: begin
        // prev scaled to Q4.60 minus the tangent share
        if (mul_take) begin
          w_r[k_r[1:0]] <= ({{32{prev_r[k_r[1:0]][31]}}, prev_r[k_r[1:0]]} <<< 30)
                           - mul_rsp.prod[63:0];
        end
      end
      ST_YRND: begin
        y_r[k_r[1:0]] <= rnd_sat(sel3_64(k_r[1:0], w_r[0], w_r[1], w_r[2]));
      end
      ST_EMIT: begin
        if (out_free) begin
          out_r.axis_x_x <= x_r[0];
          out_r.axis_x_y <= x_r[1];
          out_r.axis_x_z <= x_r[2];
          out_r.axis_y_x <= y_r[0];
          out_r.axis_y_y <= y_r[1];
          out_r.axis_y_z <= y_r[2];
          out_r.axis_z_x <= z_r[0];
          out_r.axis_z_y <= z_r[1];
          out_r.axis_z_z <= z_r[2];
          out_r.status   <= status_r;
        end
      end
      default: begin
        acc_r <= acc_r;
      end
    endcase
  end

  // checks
  a_mul_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    mul_rsp.done |-> wait_r && mul_state)
    else $error("multiplier result with no product outstanding");

  a_ds_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    ds_rsp.done |-> wait_r && ((state_r == ST_NSQRT) || (state_r == ST_NDIV)))
    else $error("root/divide result with no request outstanding");

  a_unit_normal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (z_r[0] <= ONE_Q30) && (z_r[0] >= -ONE_Q30) &&
                             (z_r[1] <= ONE_Q30) && (z_r[1] >= -ONE_Q30) &&
                             (z_r[2] <= ONE_Q30) && (z_r[2] >= -ONE_Q30))
    else $error("normal component beyond unit range");

  a_ztan_axis: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && status_r == STAT_ZTAN) |->
      (x_r[0] == 32'sd0) && (x_r[1] == 32'sd0) && (x_r[2] == 32'sd0))
    else $error("zero tangent with nonzero axis x");

endmodule
